// ===== rtl/tfp_pkg.sv =====
// ----------------------------------------------------------------------------
// tfp_pkg
// Shared constants, types and helpers of the telemetry frame parser.
// ----------------------------------------------------------------------------
package tfp_pkg;

	localparam int CELL_COUNT  = 6;
	localparam int STORE_DEPTH = 2 * CELL_COUNT + 9;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int COUNT_W     = 5;
	localparam int INDEX_W     = 4;
	localparam int VALUE_W     = 17;

	localparam logic [7:0] HDR_CURRENT     = 8'h61;
	localparam logic [7:0] HDR_TEMPERATURE = 8'h62;
	localparam logic [7:0] HDR_BATTERY     = 8'h63;
	localparam logic [7:0] HDR_SPEED       = 8'h64;
	localparam logic [7:0] END_MARK        = 8'h3B;

	localparam logic [1:0] KIND_CURRENT     = 2'd0;
	localparam logic [1:0] KIND_TEMPERATURE = 2'd1;
	localparam logic [1:0] KIND_BATTERY     = 2'd2;
	localparam logic [1:0] KIND_SPEED       = 2'd3;

	localparam logic [COUNT_W-1:0] SIZE_CURRENT     = COUNT_W'(4);
	localparam logic [COUNT_W-1:0] SIZE_TEMPERATURE = COUNT_W'(8);
	localparam logic [COUNT_W-1:0] SIZE_BATTERY     = COUNT_W'(STORE_DEPTH);
	localparam logic [COUNT_W-1:0] SIZE_SPEED       = COUNT_W'(2);
	localparam logic [COUNT_W-1:0] DEPTH_C          = COUNT_W'(STORE_DEPTH);

	// battery: cell voltages plus four 16-bit words, then the charge byte
	localparam logic [INDEX_W-1:0] BATT_WORDS = INDEX_W'(CELL_COUNT + 4);

	// per-field control from the sequencer to the word assembler
	typedef struct packed {
		logic               cap_hi;
		logic               cap_word;
		logic               cap_charge;
		logic               is_signed;
		logic [1:0]         kind;
		logic [INDEX_W-1:0] index;
		logic               last;
	} emit_ctl_t;

	function automatic logic [COUNT_W-1:0] kind_size(input logic [1:0] kind);
		logic [COUNT_W-1:0] s;
		unique case (kind)
			KIND_CURRENT:     s = SIZE_CURRENT;
			KIND_TEMPERATURE: s = SIZE_TEMPERATURE;
			KIND_BATTERY:     s = SIZE_BATTERY;
			default:          s = SIZE_SPEED;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/tfp_payload_mem.sv =====
// ----------------------------------------------------------------------------
// tfp_payload_mem
// Payload byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tfp_payload_mem
	import tfp_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem_q [STORE_DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/tfp_sequencer.sv =====
// ----------------------------------------------------------------------------
// tfp_sequencer
// Frame parser and field emission sequencer around the payload store.
// ----------------------------------------------------------------------------
module tfp_sequencer
	import tfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              mem_we,
	output logic [ADDR_W-1:0] mem_waddr,
	output logic              mem_re,
	output logic [ADDR_W-1:0] mem_raddr,
	output emit_ctl_t         ctl
);

	typedef enum logic [2:0] {
		ST_HEADER,
		ST_PAYLOAD,
		ST_TERM,
		ST_DISCARD,
		ST_RD_HI,
		ST_RD_LO,
		ST_WORD,
		ST_OUT
	} state_t;

	state_t             state_q;
	logic [1:0]         kind_q;
	logic [COUNT_W-1:0] count_q;
	logic [INDEX_W-1:0] field_q;

	logic               accept;
	logic [COUNT_W-1:0] count_nxt;
	logic               is_charge;
	logic [INDEX_W-1:0] words;
	logic [INDEX_W+1:0] pos_hi;
	logic [INDEX_W+1:0] pos_lo;

	assign in_ready  = (state_q == ST_HEADER) || (state_q == ST_PAYLOAD) ||
	                   (state_q == ST_TERM) || (state_q == ST_DISCARD);
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == ST_OUT);
	assign count_nxt = count_q + COUNT_W'(1);

	// store payload bytes as they arrive
	assign mem_we    = accept && (state_q == ST_PAYLOAD) && (count_q < DEPTH_C);
	assign mem_waddr = count_q[ADDR_W-1:0];

	assign is_charge = (kind_q == KIND_BATTERY) && (field_q == BATT_WORDS);
	assign words     = INDEX_W'(kind_size(kind_q) >> 1);
	assign pos_hi    = {1'b0, field_q, 1'b0};
	assign pos_lo    = {1'b0, field_q, 1'b1};

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = pos_hi[ADDR_W-1:0];
		if (state_q == ST_RD_HI) begin
			mem_re = 1'b1;
		end else if (state_q == ST_RD_LO && !is_charge) begin
			mem_re    = 1'b1;
			mem_raddr = pos_lo[ADDR_W-1:0];
		end
	end

	always_comb begin
		ctl.cap_hi     = (state_q == ST_RD_LO) && !is_charge;
		ctl.cap_charge = (state_q == ST_RD_LO) && is_charge;
		ctl.cap_word   = (state_q == ST_WORD);
		ctl.is_signed  = (kind_q == KIND_CURRENT) || (kind_q == KIND_TEMPERATURE);
		ctl.kind       = kind_q;
		ctl.index      = field_q;
		if (kind_q == KIND_BATTERY) begin
			ctl.last = is_charge;
		end else begin
			ctl.last = (field_q == words - INDEX_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HEADER;
			kind_q  <= KIND_CURRENT;
			count_q <= '0;
			field_q <= '0;
		end else begin
			unique case (state_q)
				ST_HEADER: begin
					if (accept) begin
						if (data_byte >= HDR_CURRENT && data_byte <= HDR_SPEED) begin
							kind_q  <= data_byte[1:0] - HDR_CURRENT[1:0];
							count_q <= '0;
							state_q <= ST_PAYLOAD;
						end else if (data_byte != END_MARK) begin
							state_q <= ST_DISCARD;
						end
					end
				end
				ST_PAYLOAD: begin
					if (accept) begin
						count_q <= count_nxt;
						if (count_nxt >= kind_size(kind_q)) begin
							state_q <= ST_TERM;
						end
					end
				end
				ST_TERM: begin
					if (accept) begin
						if (data_byte == END_MARK) begin
							field_q <= '0;
							state_q <= ST_RD_HI;
						end else begin
							state_q <= ST_DISCARD;
						end
					end
				end
				ST_DISCARD: begin
					if (accept && data_byte == END_MARK) begin
						state_q <= ST_HEADER;
					end
				end
				ST_RD_HI: begin
					state_q <= ST_RD_LO;
				end
				ST_RD_LO: begin
					state_q <= is_charge ? ST_OUT : ST_WORD;
				end
				ST_WORD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						if (ctl.last) begin
							state_q <= ST_HEADER;
						end else begin
							field_q <= field_q + INDEX_W'(1);
							state_q <= ST_RD_HI;
						end
					end
				end
				default: begin
					state_q <= ST_HEADER;
				end
			endcase
		end
	end

endmodule

// ===== rtl/telemetry_frame_parser.sv =====
// ----------------------------------------------------------------------------
// telemetry_frame_parser
// Telemetry byte stream parser that emits decoded packet fields.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, data_byte) takes one stream byte per
//   word. A header byte 'a'..'d' opens a frame; its data bytes and a ';'
//   terminator follow. Each byte is taken in one cycle while the block parses.
//   Output channel (out_valid/out_ready) carries one decoded field per word:
//   packet_kind, field_index, field_value and last_field.
//   Field emission: after the terminator is taken, each field passes
//   through the payload store's single read port (high byte, low byte,
//   assemble) and then the output register; the next field's reads start
//   only once the receiver has taken the current one. The charge field of
//   a battery frame needs only the high-byte read. in_ready is low for the
//   whole emission run and rises the cycle after the last field is taken.
//   A stalled receiver holds the current field steady; the sequencer waits.
//   Reset clears the parse state to waiting for a header; the payload store
//   is not cleared, every byte is written before it is read.
// ----------------------------------------------------------------------------
module telemetry_frame_parser
	import tfp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                data_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                packet_kind,
	output logic [INDEX_W-1:0]        field_index,
	output logic signed [VALUE_W-1:0] field_value,
	output logic                      last_field
);

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [7:0]        mem_rdata;
	emit_ctl_t         ctl;

	logic [7:0]                hi_q;
	logic [1:0]                kind_q;
	logic [INDEX_W-1:0]        index_q;
	logic signed [VALUE_W-1:0] value_q;
	logic                      last_q;

	tfp_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.ctl       (ctl)
	);

	tfp_payload_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (data_byte),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Assemble one big-endian field: hold the high byte, then join the low
	// byte and extend. The output register is loaded only while out_valid is
	// low, so a stalled word never changes.
	always_ff @(posedge clk) begin
		if (ctl.cap_hi) begin
			hi_q <= mem_rdata;
		end
		if (ctl.cap_word) begin
			value_q <= {ctl.is_signed & hi_q[7], hi_q, mem_rdata};
			kind_q  <= ctl.kind;
			index_q <= ctl.index;
			last_q  <= ctl.last;
		end else if (ctl.cap_charge) begin
			// charge byte: zero-extend
			value_q <= {{(VALUE_W-8){1'b0}}, mem_rdata};
			kind_q  <= ctl.kind;
			index_q <= ctl.index;
			last_q  <= ctl.last;
		end
	end

	assign packet_kind = kind_q;
	assign field_index = index_q;
	assign field_value = value_q;
	assign last_field  = last_q;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the telemetry frame parser. A queue of stream bytes
// (directed frames first, then mostly well-formed random frames mixed with
// noise and broken frames) is offered over the input channel with random
// gaps. Every accepted byte runs through a local parser model that queues the
// decoded fields it expects; every word taken from the output channel is
// checked field by field against the oldest of them.
// ----------------------------------------------------------------------------
module testbench;
	import tfp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BYTES   = 410;
	localparam int HOLD_AT        = 60;   // bytes taken before the long receiver stall
	localparam int HOLD_LEN       = 400;  // length of that stall in cycles
	localparam int WATCHDOG_LIMIT = 3000; // cycles with no word moving on either side
	localparam int DRAIN_CYCLES   = 20;
	localparam int MAX_REPORTS    = 10;

	// parser phases of the local model
	typedef enum logic [1:0] {
		WAIT_HDR,
		COLLECT,
		EXPECT_END,
		SKIP_TO_END
	} parse_phase_t;

	// one decoded field as it should leave the block
	typedef struct packed {
		logic [1:0]                kind;
		logic [INDEX_W-1:0]        index;
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} field_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [7:0]                data_byte = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [1:0]                packet_kind;
	logic [INDEX_W-1:0]        field_index;
	logic signed [VALUE_W-1:0] field_value;
	logic                      last_field;

	telemetry_frame_parser u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.packet_kind (packet_kind),
		.field_index (field_index),
		.field_value (field_value),
		.last_field  (last_field)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stream bytes waiting to be offered, and decoded fields waiting to arrive
	logic [7:0] stream_q [$];
	field_t     field_q [$];
	int         stream_total = 0;
	int         bytes_taken = 0;
	int         mismatches = 0;

	// local copy of the parser state
	parse_phase_t       phase = WAIT_HDR;
	logic [1:0]         cur_kind = KIND_CURRENT;
	logic [COUNT_W-1:0] stored = '0;
	logic [7:0]         payload [STORE_DEPTH];

	// Advance the parser model by one byte; queue the fields of a frame whose
	// terminator is right.
	task automatic parse_byte(input logic [7:0] b);
		logic [COUNT_W-1:0] frame_len;
		int                 n_words;
		logic               signed_kind;
		field_t             f;

		case (cur_kind)
			KIND_CURRENT:     frame_len = SIZE_CURRENT;
			KIND_TEMPERATURE: frame_len = SIZE_TEMPERATURE;
			KIND_BATTERY:     frame_len = SIZE_BATTERY;
			default:          frame_len = SIZE_SPEED;
		endcase
		case (phase)
			WAIT_HDR: begin
				if (b >= HDR_CURRENT && b <= HDR_SPEED) begin
					cur_kind = 2'(b - HDR_CURRENT);
					stored = '0;
					phase = COLLECT;
				end else if (b != END_MARK) begin
					phase = SKIP_TO_END;
				end
			end
			COLLECT: begin
				// a ';' here is plain data
				if (stored < DEPTH_C)
					payload[stored] = b;
				stored = stored + 1'b1;
				if (stored >= frame_len)
					phase = EXPECT_END;
			end
			EXPECT_END: begin
				if (b == END_MARK) begin
					phase = WAIT_HDR;
					signed_kind = (cur_kind == KIND_CURRENT || cur_kind == KIND_TEMPERATURE);
					n_words = (cur_kind == KIND_BATTERY) ? int'(BATT_WORDS) : int'(frame_len) / 2;
					f.kind = cur_kind;
					for (int i = 0; i < n_words; i++) begin
						f.index = INDEX_W'(i);
						f.value = {signed_kind & payload[ADDR_W'(2*i)][7],
							payload[ADDR_W'(2*i)], payload[ADDR_W'(2*i+1)]};
						f.last = (cur_kind != KIND_BATTERY) && (i == n_words - 1);
						field_q.push_back(f);
					end
					// battery frames close with the charge byte, zero-extended
					if (cur_kind == KIND_BATTERY) begin
						f.index = BATT_WORDS;
						f.value = {9'd0, payload[ADDR_W'(2*BATT_WORDS)]};
						f.last = 1'b1;
						field_q.push_back(f);
					end
				end else begin
					phase = SKIP_TO_END;
				end
			end
			default: begin
				if (b == END_MARK)
					phase = WAIT_HDR;
			end
		endcase
	endtask

	// Sender: hold the byte until it is taken, then wait out the gap drawn for it.
	int send_wait = 0;
	bit send_calm = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= '0;
			send_wait = 0;
		end else if (!in_valid || in_ready) begin
			// switch now and then into a stretch without gaps
			if ($urandom_range(0, 31) == 0)
				send_calm = !send_calm;
			if (send_wait != 0) begin
				send_wait--;
				in_valid <= 1'b0;
			end else if (stream_q.size() != 0) begin
				in_valid <= 1'b1;
				data_byte <= stream_q.pop_front();
				send_wait = send_calm ? 0 : $urandom_range(0, 14);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver stall, counted here: once enough bytes have gone in, drop
	// ready for a long stretch so the block fills up and holds off the sender.
	int  hold_cycles = 0;
	bit  hold_done = 1'b0;
	wire hold_off = (hold_cycles != 0);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles <= 0;
			hold_done <= 1'b0;
		end else if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
		end else if (!hold_done && bytes_taken >= HOLD_AT) begin
			hold_cycles <= HOLD_LEN;
			hold_done <= 1'b1;
		end
	end

	// Monitor: feed taken bytes to the model, check each taken field against
	// the oldest expectation, and drive out_ready with its own random gaps.
	int     recv_wait = 0;
	bit     recv_calm = 1'b0;
	field_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait = 0;
			bytes_taken <= 0;
		end else begin
			if (in_valid && in_ready) begin
				parse_byte(data_byte);
				bytes_taken <= bytes_taken + 1;
			end
			if (out_valid && out_ready) begin
				if (field_q.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("unexpected field: kind %0d index %0d value %0d last %0d",
							packet_kind, field_index, field_value, last_field);
					mismatches++;
				end else begin
					want = field_q.pop_front();
					if (packet_kind !== want.kind || field_index !== want.index ||
						field_value !== want.value || last_field !== want.last) begin
						if (mismatches < MAX_REPORTS)
							$display("field wrong: expected kind %0d index %0d value %0d last %0d, %s",
								want.kind, want.index, want.value, want.last,
								$sformatf("got kind %0d index %0d value %0d last %0d",
									packet_kind, field_index, field_value, last_field));
						mismatches++;
					end
				end
				recv_wait = recv_calm ? 0 : $urandom_range(0, 14);
			end
			if ($urandom_range(0, 31) == 0)
				recv_calm = !recv_calm;
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (recv_wait != 0) begin
				recv_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: give up when no word has moved on either side for too long.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("telemetry_frame_parser: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Build the byte stream, release reset, then wait for everything to drain.
	initial begin : stimulus
		int         kind_pick;
		int         len;
		int         junk;
		logic [7:0] b;

		// semicolon where a header is due: dropped, still waiting for a header
		stream_q.push_back(END_MARK);
		// current frame carrying both signed extremes
		stream_q.push_back(HDR_CURRENT);
		stream_q.push_back(8'h80);
		stream_q.push_back(8'h00);
		stream_q.push_back(8'h7F);
		stream_q.push_back(8'hFF);
		stream_q.push_back(END_MARK);
		// unknown header: drop everything through the next ';'
		stream_q.push_back(8'h00);
		stream_q.push_back(8'hFF);
		stream_q.push_back(END_MARK);
		// speed frame with ';' as payload, then a wrong terminator and discard
		stream_q.push_back(HDR_SPEED);
		stream_q.push_back(END_MARK);
		stream_q.push_back(END_MARK);
		stream_q.push_back(8'h3A);
		stream_q.push_back(END_MARK);
		// speed frame at the unsigned maximum
		stream_q.push_back(HDR_SPEED);
		stream_q.push_back(8'hFF);
		stream_q.push_back(8'hFF);
		stream_q.push_back(END_MARK);
		// battery frame: words alternate between all ones and all zeros
		stream_q.push_back(HDR_BATTERY);
		for (int i = 0; i < STORE_DEPTH; i++)
			stream_q.push_back((i % 4 < 2) ? 8'hFF : 8'h00);
		stream_q.push_back(END_MARK);

		// random part: mostly well-formed frames with random payloads, plus
		// broken terminators, stray bytes and lone semicolons
		len = stream_q.size() + RANDOM_BYTES;
		while (stream_q.size() < len) begin
			kind_pick = $urandom_range(0, 19);
			if (kind_pick < 16) begin
				kind_pick = $urandom_range(0, 3);
				stream_q.push_back(8'(HDR_CURRENT + kind_pick));
				case (kind_pick)
					0: junk = int'(SIZE_CURRENT);
					1: junk = int'(SIZE_TEMPERATURE);
					2: junk = int'(SIZE_BATTERY);
					default: junk = int'(SIZE_SPEED);
				endcase
				for (int i = 0; i < junk; i++) begin
					case ($urandom_range(0, 7))
						0: b = 8'h00;
						1: b = 8'hFF;
						2: b = END_MARK;
						3: b = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
						default: b = 8'($urandom);
					endcase
					stream_q.push_back(b);
				end
				if ($urandom_range(0, 9) != 0) begin
					stream_q.push_back(END_MARK);
				end else begin
					// wrong terminator, some trailing bytes, then resync
					do b = 8'($urandom); while (b == END_MARK);
					stream_q.push_back(b);
					junk = $urandom_range(0, 3);
					for (int i = 0; i < junk; i++)
						stream_q.push_back(8'($urandom));
					stream_q.push_back(END_MARK);
				end
			end else if (kind_pick < 18) begin
				stream_q.push_back(8'($urandom));
			end else begin
				stream_q.push_back(END_MARK);
			end
		end
		stream_total = stream_q.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every byte to be taken and every field to arrive
		while (bytes_taken != stream_total)
			@(posedge clk);
		while (field_q.size() != 0)
			@(posedge clk);
		// allow a few more cycles for any stray field
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("telemetry_frame_parser: match");
		else
			$display("telemetry_frame_parser: mismatch");
		$finish;
	end

endmodule
